// File: hdl/trsp_pkg.sv
// ----------------------------------------------------------------------------
// trsp_pkg
// Shared types, constants and helper functions of the telemetry record
// symbol packer.
// ----------------------------------------------------------------------------
package trsp_pkg;

  // Symbols per record kind and the widest burst
  localparam int unsigned RemoteSyms = 3;
  localparam int unsigned LocalSyms  = 8;
  localparam int unsigned MaxSyms    = 8;
  localparam int unsigned RemW       = $clog2(MaxSyms);
  localparam int unsigned GroupW     = 6;
  localparam int unsigned WordW      = GroupW * MaxSyms;

  // Record kinds
  localparam logic CmdRemote = 1'b0;
  localparam logic CmdLocal  = 1'b1;

  // Saturation limits
  localparam logic [9:0] Temp10Max = 10'h1FF;  // +511
  localparam logic [9:0] Temp10Min = 10'h200;  // -512
  localparam logic [6:0] HumMax    = 7'd127;
  localparam logic [7:0] IdxMax    = 8'd255;
  localparam logic [3:0] RxMax     = 4'd15;

  // Input record as it arrives on the input channel
  typedef struct packed {
    logic               cmd;
    logic signed [15:0] sensor_temp;
    logic        [7:0]  humidity;
    logic               battery_weak;
    logic        [15:0] seq_index;
    logic        [7:0]  rx_count;
    logic signed [15:0] temp_internal;
    logic signed [15:0] temp_external;
    logic        [7:0]  volt_battery;
    logic        [7:0]  volt_panel;
  } in_t;

  // One symbol on the output channel
  typedef struct packed {
    logic [6:0] symbol;
    logic       last;
  } out_t;

  // Record after saturation and clamping
  typedef struct packed {
    logic       cmd;
    logic [9:0] sensor_t;
    logic [6:0] hum;
    logic       batt;
    logic [7:0] idx;
    logic [3:0] rxc;
    logic [9:0] ti;
    logic [9:0] te;
    logic [7:0] vb;
    logic [7:0] vp;
  } prep_t;

  // Packed group word, first group in the top six bits
  typedef struct packed {
    logic [WordW-1:0] bits;
    logic             is_local;
  } grp_t;

  // Signed 16-bit value to a saturated 10-bit two's complement pattern
  function automatic logic [9:0] sat10(logic signed [15:0] v);
    logic [9:0] r;
    if (v > 16'sd511) begin
      r = Temp10Max;
    end else if (v < -16'sd512) begin
      r = Temp10Min;
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

  // 6-bit group to its ASCII character: A-Z, a-z, 0-9, '.', '_'
  function automatic logic [6:0] alpha(logic [5:0] g);
    logic [6:0] c;
    if (g < 6'd26) begin
      c = 7'(g) + 7'd65;
    end else if (g < 6'd52) begin
      c = 7'(g) + 7'd71;
    end else if (g < 6'd62) begin
      c = 7'(g) - 7'd4;
    end else if (g == 6'd62) begin
      c = 7'd46;
    end else begin
      c = 7'd95;
    end
    return c;
  endfunction

endpackage

// File: hdl/trsp_prep.sv
// ----------------------------------------------------------------------------
// trsp_prep
// First pipeline stage: saturates temperatures, clamps humidity and counters.
// ----------------------------------------------------------------------------
module trsp_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  trsp_pkg::in_t  in_data_i,
  output logic           prep_valid_o,
  input  logic           prep_ready_i,
  output trsp_pkg::prep_t prep_o
);

  logic            valid_q;
  trsp_pkg::prep_t data_d, data_q;

  // stage takes a transfer when empty or draining
  assign in_ready_o = !valid_q || prep_ready_i;

  // saturation and clamping
  always_comb begin
    data_d.cmd      = in_data_i.cmd;
    data_d.sensor_t = trsp_pkg::sat10(in_data_i.sensor_temp);
    data_d.hum      = (in_data_i.humidity > 8'(trsp_pkg::HumMax)) ?
                      trsp_pkg::HumMax : in_data_i.humidity[6:0];
    data_d.batt     = in_data_i.battery_weak;
    data_d.idx      = (in_data_i.seq_index > 16'(trsp_pkg::IdxMax)) ?
                      trsp_pkg::IdxMax : in_data_i.seq_index[7:0];
    data_d.rxc      = (in_data_i.rx_count > 8'(trsp_pkg::RxMax)) ?
                      trsp_pkg::RxMax : in_data_i.rx_count[3:0];
    data_d.ti       = trsp_pkg::sat10(in_data_i.temp_internal);
    data_d.te       = trsp_pkg::sat10(in_data_i.temp_external);
    data_d.vb       = in_data_i.volt_battery;
    data_d.vp       = in_data_i.volt_panel;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign prep_valid_o = valid_q;
  assign prep_o       = data_q;

endmodule

// File: hdl/trsp_group.sv
// ----------------------------------------------------------------------------
// trsp_group
// Second pipeline stage: lays the clamped fields out as a word of 6-bit
// groups, first group at the top.
// ----------------------------------------------------------------------------
module trsp_group (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            prep_valid_i,
  output logic            prep_ready_o,
  input  trsp_pkg::prep_t prep_i,
  output logic            grp_valid_o,
  input  logic            grp_ready_i,
  output trsp_pkg::grp_t  grp_o
);

  logic           valid_q;
  trsp_pkg::grp_t data_d, data_q;

  assign prep_ready_o = !valid_q || grp_ready_i;

  // bit layout per record kind
  always_comb begin
    unique case (prep_i.cmd)
      trsp_pkg::CmdLocal: begin
        data_d.bits     = {prep_i.idx, prep_i.rxc, prep_i.ti, prep_i.te,
                           prep_i.vb, prep_i.vp};
        data_d.is_local = 1'b1;
      end
      default: begin
        data_d.bits     = {prep_i.sensor_t, prep_i.hum, prep_i.batt, 30'd0};
        data_d.is_local = 1'b0;
      end
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (prep_ready_o) begin
      valid_q <= prep_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (prep_valid_i && prep_ready_o) begin
      data_q <= data_d;
    end
  end

  assign grp_valid_o = valid_q;
  assign grp_o       = data_q;

endmodule

// File: hdl/trsp_serial.sv
// ----------------------------------------------------------------------------
// trsp_serial
// Third stage: unless the output stalls, shifts one group a cycle out of the
// word buffer, maps it through the alphabet, holds it in the output register.
// ----------------------------------------------------------------------------
module trsp_serial (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           grp_valid_i,
  output logic           grp_ready_o,
  input  trsp_pkg::grp_t grp_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output trsp_pkg::out_t out_data_o
);

  logic                          buf_valid_q;
  logic [trsp_pkg::WordW-1:0]    bits_q;
  logic [trsp_pkg::RemW-1:0]     rem_q;    // groups left after the current
  logic                          out_valid_q;
  trsp_pkg::out_t                out_q;
  logic                          emit;
  logic                          load;
  logic                          at_last;

  assign at_last     = (rem_q == '0);
  assign emit        = buf_valid_q && (!out_valid_q || out_ready_i);
  assign grp_ready_o = !buf_valid_q || (emit && at_last);
  assign load        = grp_valid_i && grp_ready_o;

  // word buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      rem_q       <= '0;
    end else if (load) begin
      buf_valid_q <= 1'b1;
      rem_q       <= grp_i.is_local ? trsp_pkg::RemW'(trsp_pkg::LocalSyms - 1)
                                    : trsp_pkg::RemW'(trsp_pkg::RemoteSyms - 1);
    end else if (emit) begin
      buf_valid_q <= !at_last;
      rem_q       <= rem_q - 1'b1;
    end
  end

  // word buffer payload: shift up one group per symbol
  always_ff @(posedge clk_i) begin
    if (load) begin
      bits_q <= grp_i.bits;
    end else if (emit) begin
      bits_q <= {bits_q[trsp_pkg::WordW-trsp_pkg::GroupW-1:0],
                 trsp_pkg::GroupW'(0)};
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.symbol <= trsp_pkg::alpha(
                        bits_q[trsp_pkg::WordW-1 -: trsp_pkg::GroupW]);
      out_q.last   <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a new word only enters once the previous one has sent its last symbol
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && buf_valid_q |-> emit && at_last)
    else $error("word buffer overwritten before last symbol");

  // final group of a word is marked last
  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && at_last |=> out_valid_q && out_q.last)
    else $error("final symbol not marked last");

  // no other group is marked last
  a_mid_unmarked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !at_last |=> out_valid_q && !out_q.last && buf_valid_q)
    else $error("intermediate symbol marked last or word lost");

endmodule

// File: hdl/telemetry_record_symbol_packer.sv
// ----------------------------------------------------------------------------
// telemetry_record_symbol_packer
// Packs one telemetry record per input transfer into a burst of 7-bit
// alphabet characters, one 6-bit group per output transfer.
// ----------------------------------------------------------------------------
// A remote sensor record (cmd 0) gives 3 symbols, a local record (cmd 1)
// gives 8; the final symbol of each record carries last. The record passes a
// clamp stage, a group layout stage and a serialiser with an output register.
// The serialiser sends one symbol per cycle while the output is not stalled,
// and loads the next record's word as it sends the last symbol of the current
// one, with the next records already accepted into the earlier stages
// meanwhile.
module telemetry_record_symbol_packer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  trsp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output trsp_pkg::out_t out_data_o
);

  logic            prep_valid, prep_ready;
  trsp_pkg::prep_t prep;
  logic            grp_valid, grp_ready;
  trsp_pkg::grp_t  grp;

  // clamp and saturate
  trsp_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .prep_valid_o (prep_valid),
    .prep_ready_i (prep_ready),
    .prep_o       (prep)
  );

  // group layout
  trsp_group u_group (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prep_valid_i (prep_valid),
    .prep_ready_o (prep_ready),
    .prep_i       (prep),
    .grp_valid_o  (grp_valid),
    .grp_ready_i  (grp_ready),
    .grp_o        (grp)
  );

  // serialiser and output register
  trsp_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_ready_o (grp_ready),
    .grp_i       (grp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
